[design/ftm_pkg.sv]
// Package for the flow timeout manager: opcodes, status codes, shared types.
// Used by flow_timeout_manager_top, ftm_front and ftm_back.
package ftm_pkg;
	localparam int US_PER_S = 1000000;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POP = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_DELETED = 2'd1,
		ST_EXPIRED = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [63:0] flow_key;
		logic [2:0] timer_type;
		logic [31:0] timeout_seconds;
		logic [31:0] context_tag;
		logic [31:0] flow_ref;
		logic [63:0] now_us;
		logic [63:0] new_expire;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [63:0] out_key;
		logic [2:0] out_type;
		logic [31:0] out_seconds;
		logic [63:0] out_expire;
		logic [31:0] out_context;
		logic [31:0] out_flow_ref;
	} rsp_t;
endpackage

[design/flow_timeout_manager_top.sv]
// Flow timeout manager top: front end, command queue, table back end.
// The back end scans the table one slot per cycle on a single-port RAM, then
// reads and may write the chosen slot when a slot is touched, and it takes a
// new item only once it is through with the last one. The front accepts the
// next item while the back works.
// Reset clears slot valid bits and control at once; no clearing pass.
// Depends on ftm_pkg, ftm_front, ftm_back, ftm_ram.
module flow_timeout_manager_top #(
	parameter int ENTRIES = 256,
	parameter int KEY_BITS = 64,
	parameter int TYPES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [63:0] flow_key,
	input logic [2:0] timer_type,
	input logic [31:0] timeout_seconds,
	input logic [31:0] context_tag,
	input logic [31:0] flow_ref,
	input logic [63:0] now_us,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [63:0] out_key,
	output logic [2:0] out_type,
	output logic [31:0] out_seconds,
	output logic [63:0] out_expire,
	output logic [31:0] out_context,
	output logic [31:0] out_flow_ref
);
	import ftm_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;
	rsp_t rsp;

	ftm_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .flow_key(flow_key), .timer_type(timer_type),
		.timeout_seconds(timeout_seconds), .context_tag(context_tag),
		.flow_ref(flow_ref), .now_us(now_us),
		.cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
	);

	ftm_back #(.ENTRIES(ENTRIES), .TYPES(TYPES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.cmd(cmd), .rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(rsp)
	);

	assign status = rsp.status;
	assign out_key = rsp.out_key;
	assign out_type = rsp.out_type;
	assign out_seconds = rsp.out_seconds;
	assign out_expire = rsp.out_expire;
	assign out_context = rsp.out_context;
	assign out_flow_ref = rsp.out_flow_ref;
endmodule

[design/ftm_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module ftm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[design/ftm_front.sv]
// Front end: accepts items, masks the key, precomputes the set expiry
// (split multiply), and pushes commands into a two-entry queue.
// Depends on ftm_pkg.
module ftm_front #(
	parameter int KEY_BITS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [63:0] flow_key,
	input logic [2:0] timer_type,
	input logic [31:0] timeout_seconds,
	input logic [31:0] context_tag,
	input logic [31:0] flow_ref,
	input logic [63:0] now_us,
	output logic cmd_valid,
	input logic cmd_pop,
	output ftm_pkg::cmd_t cmd
);
	import ftm_pkg::*;

	localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

	cmd_t item_q;
	logic busy_q;
	logic [1:0] phase_q;
	logic [51:0] prod_lo_q;
	logic [51:0] prod_hi_q;
	cmd_t fifo_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;
	logic [63:0] expire;
	cmd_t push_cmd;

	assign in_ready = !busy_q;
	assign expire = item_q.now_us + {12'd0, prod_lo_q} + {prod_hi_q[47:0], 16'd0};
	assign push = busy_q && phase_q == 2'd2 && cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = fifo_q[rd_q];

	always_comb begin
		push_cmd = item_q;
		push_cmd.new_expire = expire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				phase_q <= 2'd0;
			end else if (busy_q && phase_q != 2'd2) begin
				phase_q <= phase_q + 2'd1;
			end else if (push) begin
				busy_q <= 1'b0;
			end
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop && cmd_valid) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q.opcode <= opcode;
			item_q.flow_key <= flow_key & KEY_MASK;
			item_q.timer_type <= timer_type;
			item_q.timeout_seconds <= timeout_seconds;
			item_q.context_tag <= context_tag;
			item_q.flow_ref <= flow_ref;
			item_q.now_us <= now_us;
			item_q.new_expire <= '0;
		end
		if (busy_q && phase_q == 2'd0) begin
			prod_lo_q <= {20'd0, item_q.timeout_seconds[15:0]} * 52'(US_PER_S);
			prod_hi_q <= {20'd0, item_q.timeout_seconds[31:16]} * 52'(US_PER_S);
		end
		if (push) begin
			fifo_q[wr_q] <= push_cmd;
		end
	end
endmodule

[design/ftm_back.sv]
// Back end: scans the timer table one slot per cycle for a key match,
// free slot, or earliest expiry, then may update the chosen slot and emits one result.
// Depends on ftm_pkg and ftm_ram.
module ftm_back #(
	parameter int ENTRIES = 256,
	parameter int TYPES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_pop,
	input ftm_pkg::cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_ready,
	output ftm_pkg::rsp_t rsp
);
	import ftm_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int SW = 64 + 3 + 64 + 32 + 32 + 32;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_SCAN = 8'b00000010,
		S_LAST = 8'b00000100,
		S_PICK = 8'b00001000,
		S_RD = 8'b00010000,
		S_MUL = 8'b00100000,
		S_UPD = 8'b01000000,
		S_OUT = 8'b10000000
	} state_t;

	state_t state_q;
	cmd_t c_q;
	logic [ENTRIES-1:0] valid_q;
	logic [AW:0] idx_q;
	logic [AW-1:0] rd_idx_q;
	logic rd_ok_q;
	logic match_f_q, free_f_q, best_f_q;
	logic [AW-1:0] match_q, free_q, best_q;
	logic [63:0] best_exp_q;
	logic [AW-1:0] addr;
	logic we;
	logic [SW-1:0] wdata, rdata;
	logic [63:0] r_key, r_exp;
	logic [2:0] r_type;
	logic [31:0] r_sec, r_ctx, r_ref;
	logic [AW-1:0] tgt_q;
	logic [51:0] plo_q, phi_q;
	rsp_t rsp_q;
	logic type_ok;
	logic [63:0] resched;

	assign {r_key, r_type, r_exp, r_sec, r_ctx, r_ref} = rdata;
	assign type_ok = {29'd0, c_q.timer_type} < 32'(TYPES);
	assign resched = c_q.now_us + {12'd0, plo_q} + {phi_q[47:0], 16'd0};

	ftm_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_tab (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_comb begin
		addr = idx_q[AW-1:0];
		we = 1'b0;
		wdata = rdata;
		if (state_q == S_RD || state_q == S_MUL) begin
			addr = tgt_q;
		end
		if (state_q == S_UPD) begin
			addr = tgt_q;
			case (c_q.opcode)
				OP_SET: begin
					we = 1'b1;
					if (match_f_q) begin
						wdata = {r_key, r_type,
							(c_q.timeout_seconds != 32'd0) ? c_q.new_expire : r_exp,
							c_q.timeout_seconds, r_ctx, r_ref};
					end else begin
						wdata = {c_q.flow_key, c_q.timer_type, c_q.new_expire,
							c_q.timeout_seconds, c_q.context_tag, c_q.flow_ref};
					end
				end
				OP_REMOVE: begin
					we = 1'b1;
					wdata = {r_key, r_type, r_exp, 32'd0, r_ctx, r_ref};
				end
				OP_POP: begin
					we = r_sec != 32'd0 && c_q.now_us > r_exp;
					wdata = {r_key, r_type, resched, r_sec, r_ctx, r_ref};
				end
				default: we = 1'b0;
			endcase
		end
	end

	assign cmd_pop = state_q == S_IDLE && cmd_valid;
	assign rsp_valid = state_q == S_OUT;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			idx_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_SCAN;
						idx_q <= '0;
						rd_ok_q <= 1'b0;
					end
				end
				S_SCAN: begin
					rd_ok_q <= 1'b1;
					if (idx_q == (AW+1)'(ENTRIES - 1)) begin
						state_q <= S_LAST;
					end else begin
						idx_q <= idx_q + (AW+1)'(1);
					end
				end
				S_LAST: begin
					rd_ok_q <= 1'b0;
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_OUT;
					if (c_q.opcode == OP_SET && type_ok) begin
						if (match_f_q || free_f_q) begin
							state_q <= S_RD;
						end
					end else if (c_q.opcode == OP_REMOVE && type_ok) begin
						if (match_f_q) begin
							state_q <= S_RD;
						end
					end else if (c_q.opcode == OP_POP && best_f_q) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_MUL;
				S_MUL: state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_OUT;
					if (c_q.opcode == OP_SET && !match_f_q) begin
						valid_q[tgt_q] <= 1'b1;
					end
					if (c_q.opcode == OP_POP && r_sec == 32'd0) begin
						valid_q[tgt_q] <= 1'b0;
					end
				end
				S_OUT: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			c_q <= cmd;
			match_f_q <= 1'b0;
			free_f_q <= 1'b0;
			best_f_q <= 1'b0;
			rsp_q <= '0;
		end
		if (state_q == S_SCAN) begin
			rd_idx_q <= idx_q[AW-1:0];
		end
		if ((state_q == S_SCAN || state_q == S_LAST) && rd_ok_q) begin
			if (valid_q[rd_idx_q]) begin
				if (!match_f_q && r_type == c_q.timer_type && r_key == c_q.flow_key) begin
					match_f_q <= 1'b1;
					match_q <= rd_idx_q;
				end
				if (!best_f_q || r_exp < best_exp_q) begin
					best_f_q <= 1'b1;
					best_q <= rd_idx_q;
					best_exp_q <= r_exp;
				end
			end else if (!free_f_q) begin
				free_f_q <= 1'b1;
				free_q <= rd_idx_q;
			end
		end
		if (state_q == S_PICK) begin
			if (c_q.opcode == OP_POP) begin
				tgt_q <= best_q;
			end else if (match_f_q) begin
				tgt_q <= match_q;
			end else begin
				tgt_q <= free_q;
			end
			if (c_q.opcode == OP_SET && type_ok && !match_f_q && !free_f_q) begin
				rsp_q.status <= ST_FULL;
			end
		end
		if (state_q == S_MUL) begin
			plo_q <= {20'd0, r_sec[15:0]} * 52'(US_PER_S);
			phi_q <= {20'd0, r_sec[31:16]} * 52'(US_PER_S);
		end
		if (state_q == S_UPD && c_q.opcode == OP_POP) begin
			if (r_sec == 32'd0 || c_q.now_us > r_exp) begin
				rsp_q.status <= (r_sec == 32'd0) ? ST_DELETED : ST_EXPIRED;
				rsp_q.out_key <= r_key;
				rsp_q.out_type <= r_type;
				rsp_q.out_seconds <= r_sec;
				rsp_q.out_expire <= r_exp;
				rsp_q.out_context <= r_ctx;
				rsp_q.out_flow_ref <= r_ref;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q == S_SCAN)
		else $error("scan did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_q))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $past(state_q) == S_MUL)
		else $error("update out of order");
endmodule
